/* sv/kqsb_pkg.sv */
// Package for the shared-buffer multi-queue block.
// Holds sizes, slot encodings, status codes and controller command types.
// No dependencies; every other file imports it.
package kqsb_pkg;

  localparam int NUM_QUEUES = 4;
  localparam int CAPACITY   = 16;

  localparam int QID_W  = 2;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(CAPACITY);
  // A slot pointer must also hold the null code, which equals CAPACITY.
  localparam int SLOT_W = $clog2(CAPACITY + 1);

  localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(CAPACITY);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef struct packed {
    logic accept;   // latch the request and launch the memory reads
    logic commit;   // apply the update and load the result register
  } kqsb_cmd_t;

endpackage

/* sv/kqsb_ctrl.sv */
// Controller for the shared-buffer multi-queue block.
// Sequences accept, memory read and commit; owns the result valid flag.
// Depends on kqsb_pkg.
module kqsb_ctrl
  import kqsb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output kqsb_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.accept = (state_r == S_IDLE) && in_valid;
    // The result register must be free, or emptied in this same cycle.
    cmd.commit = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* sv/kqsb_dp.sv */
// Datapath for the shared-buffer multi-queue block.
// Holds queue pointers, the free list head, link and data memories, result register.
// Depends on kqsb_pkg.
module kqsb_dp
  import kqsb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  kqsb_cmd_t                cmd,
  input  logic                     in_op,
  input  logic [QID_W-1:0]         in_queue_id,
  input  logic signed [DATA_W-1:0] in_data_in,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_data_out
);

  // Request registers.
  logic                     op_r;
  logic [QID_W-1:0]         q_r;
  logic signed [DATA_W-1:0] data_r;

  // Queue state.
  logic [IDX_W-1:0]  head_r [NUM_QUEUES];
  logic [IDX_W-1:0]  tail_r [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] empty_r;
  logic [SLOT_W-1:0] free_head_r;

  // Memories and their read registers.
  logic [SLOT_W-1:0]        link_mem [CAPACITY];
  logic signed [DATA_W-1:0] data_mem [CAPACITY];
  logic [CAPACITY-1:0]      lvalid_r;
  logic [IDX_W-1:0]         rd_addr_r;
  logic [SLOT_W-1:0]        link_rd_r;
  logic                     lvalid_rd_r;
  logic signed [DATA_W-1:0] data_rd_r;

  logic [1:0]               status_r;
  logic signed [DATA_W-1:0] result_r;

  logic                     in_q_ok;
  logic [IDX_W-1:0]         rd_addr;
  logic [SLOT_W-1:0]        link_val;
  logic                     q_ok;
  logic                     enq_ok;
  logic                     deq_ok;
  logic                     link_we;
  logic [IDX_W-1:0]         link_wa;
  logic [SLOT_W-1:0]        link_wd;
  logic                     data_we;
  logic [IDX_W-1:0]         enq_slot;
  logic [IDX_W-1:0]         deq_slot;

  // Read address: the free list head for an enqueue, the queue head for a dequeue.
  always_comb begin
    in_q_ok = (int'(in_queue_id) < NUM_QUEUES);
    rd_addr = free_head_r[IDX_W-1:0];
    if (in_op == OP_DEQ) begin
      rd_addr = in_q_ok ? head_r[in_queue_id] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r        <= in_op;
      q_r         <= in_queue_id;
      data_r      <= in_data_in;
      rd_addr_r   <= rd_addr;
      link_rd_r   <= link_mem[rd_addr];
      lvalid_rd_r <= lvalid_r[rd_addr];
      data_rd_r   <= data_mem[rd_addr];
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (data_we) begin
      data_mem[enq_slot] <= data_r;
    end
  end

  // An entry never written holds its reset link, the next slot index;
  // for the last slot that sum is exactly the null code.
  assign link_val = lvalid_rd_r ? link_rd_r : (SLOT_W'(rd_addr_r) + SLOT_W'(1));

  always_comb begin
    q_ok     = (int'(q_r) < NUM_QUEUES);
    enq_ok   = (op_r == OP_ENQ) && q_ok && (free_head_r != NULL_SLOT);
    deq_ok   = (op_r == OP_DEQ) && q_ok && !empty_r[q_r];
    enq_slot = free_head_r[IDX_W-1:0];
    deq_slot = q_ok ? head_r[q_r] : '0;

    // Enqueue onto a non-empty queue chains the new slot after the tail.
    // The tail's own link is never consulted: head equal to tail marks the last item.
    link_we = 1'b0;
    link_wa = q_ok ? tail_r[q_r] : '0;
    link_wd = SLOT_W'(enq_slot);
    data_we = 1'b0;
    if (cmd.commit) begin
      if (enq_ok) begin
        data_we = 1'b1;
        link_we = !empty_r[q_r];
      end else if (deq_ok) begin
        link_we = 1'b1;
        link_wa = deq_slot;
        link_wd = free_head_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
      empty_r     <= '1;
      free_head_r <= '0;
      lvalid_r    <= '0;
    end else begin
      if (link_we) begin
        lvalid_r[link_wa] <= 1'b1;
      end
      if (cmd.commit && enq_ok) begin
        free_head_r <= link_val;
        tail_r[q_r] <= enq_slot;
        if (empty_r[q_r]) begin
          head_r[q_r]  <= enq_slot;
          empty_r[q_r] <= 1'b0;
        end
      end
      if (cmd.commit && deq_ok) begin
        free_head_r <= SLOT_W'(deq_slot);
        if (head_r[q_r] == tail_r[q_r]) begin
          empty_r[q_r] <= 1'b1;
          head_r[q_r]  <= '0;
        end else begin
          head_r[q_r] <= link_val[IDX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (op_r == OP_ENQ) begin
        status_r <= enq_ok ? ST_OK : ST_FULL;
        result_r <= '0;
      end else begin
        status_r <= deq_ok ? ST_OK : ST_EMPTY;
        result_r <= deq_ok ? data_rd_r : '0;
      end
    end
  end

  assign out_status   = status_r;
  assign out_data_out = result_r;

endmodule

/* sv/k_queues_shared_buffer_unit.sv */
// Top level of the shared-buffer multi-queue block: several FIFO queues in one store.
// A request is accepted in the idle state, which latches it and launches the registered
// read of the link and data memories; the commit then writes them back and loads the
// result register, once that is free. No new request is taken before the commit.
// Reset (rst_n, synchronous, active low) empties all queues and rebuilds the free
// list at once through per-entry link valid bits. Depends on kqsb_pkg, kqsb_ctrl, kqsb_dp.
module k_queues_shared_buffer_unit
  import kqsb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_op,
  input  logic [QID_W-1:0]         in_queue_id,
  input  logic signed [DATA_W-1:0] in_data_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_data_out
);

  // The controller accepts a request beat in its idle state, which launches the
  // memory reads in the datapath. It then commits the update in its execute state,
  // once the result register is free or is being drained in that cycle.
  // A finished result may wait in the output register while the next request
  // beat is accepted, so the two sides are decoupled by one item.
  kqsb_cmd_t cmd;

  kqsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The datapath keeps the queue head and tail pointers, the empty flags, the
  // free list head, the link memory that chains slots, and the data memory.
  kqsb_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_op        (in_op),
    .in_queue_id  (in_queue_id),
    .in_data_in   (in_data_in),
    .out_status   (out_status),
    .out_data_out (out_data_out)
  );

endmodule

/* sv/kqsb_checker.sv */
// Port-level checker for the shared-buffer multi-queue block, with its bind.
// Depends on kqsb_pkg and k_queues_shared_buffer_unit.
module kqsb_checker
  import kqsb_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [1:0]               out_status,
  input logic signed [DATA_W-1:0] out_data_out
);

  // One request at a time: right after an accepted beat, the input stalls.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_FULL || out_status == ST_EMPTY))
    else $error("undefined status code");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_data_out == '0))
    else $error("failed operation returned nonzero data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) && $stable(out_data_out)))
    else $error("stalled result changed");

endmodule

bind k_queues_shared_buffer_unit kqsb_checker u_kqsb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_status   (out_status),
  .out_data_out (out_data_out)
);

/* test/k_queues_shared_buffer_unit_test.sv */
// Self-checking testbench for k_queues_shared_buffer_unit: a directed table, then random
// enqueue/dequeue traffic with random idling on both channels and one long output hold-off.
// Depends on kqsb_pkg and the k_queues_shared_buffer_unit RTL only.
module k_queues_shared_buffer_unit_test
  import kqsb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS_PER_PHASE = 500;
  localparam int HOLD_OFF_CYCLES        = 60;
  localparam int DRAIN_CYCLES           = 8;

  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  // One result beat as the block should return it.
  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
  } queue_result_t;

  // One request beat. Rows with a known answer carry it; all others rely on the
  // shadow queue state below.
  typedef struct {
    logic                     op;
    logic [QID_W-1:0]         qid;
    logic signed [DATA_W-1:0] data;
    bit                       known;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] dout;
  } queue_request_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_op;
  logic [QID_W-1:0]         in_queue_id;
  logic signed [DATA_W-1:0] in_data_in;
  logic                     out_valid;
  logic                     out_stall;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_data_out;

  // Shadow copy of the linked-slot store: per-queue head, tail and empty flag,
  // the slot chain and the free list.
  logic [SLOT_W-1:0]        shadow_head [NUM_QUEUES];
  logic [SLOT_W-1:0]        shadow_tail [NUM_QUEUES];
  logic                     shadow_empty[NUM_QUEUES];
  logic [SLOT_W-1:0]        shadow_link [CAPACITY];
  logic signed [DATA_W-1:0] shadow_data [CAPACITY];
  logic [SLOT_W-1:0]        shadow_free;

  queue_result_t  awaited_results[$];
  queue_request_t directed_rows[$];
  int             mismatch_count;
  int             sender_idle_pct;
  int             receiver_idle_pct;
  bit             hold_off_request;

  k_queues_shared_buffer_unit uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_queue_id  (in_queue_id),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_data_out (out_data_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Applies one request to the shadow store and returns the answer it calls for.
  // An enqueue pops the free-list head and appends that slot to the queue; a
  // dequeue unlinks the head slot and pushes it back onto the free list. A queue
  // that drains keeps its old tail pointer, and only the empty flag matters.
  function automatic queue_result_t apply_queue_op(input logic op,
                                                   input logic [QID_W-1:0] qid,
                                                   input logic signed [DATA_W-1:0] din);
    queue_result_t     res;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] next_slot;
    res.status = ST_OK;
    res.data   = '0;
    if (op == OP_ENQ) begin
      slot = shadow_free;
      if (slot >= NULL_SLOT) begin
        res.status = ST_FULL;
      end else begin
        shadow_free = shadow_link[slot[IDX_W-1:0]];
        if (shadow_empty[qid]) begin
          shadow_head[qid]  = slot;
          shadow_empty[qid] = 1'b0;
        end else begin
          shadow_link[shadow_tail[qid][IDX_W-1:0]] = slot;
        end
        shadow_link[slot[IDX_W-1:0]] = NULL_SLOT;
        shadow_tail[qid]             = slot;
        shadow_data[slot[IDX_W-1:0]] = din;
      end
    end else begin
      if (shadow_empty[qid]) begin
        res.status = ST_EMPTY;
      end else begin
        slot      = shadow_head[qid];
        next_slot = shadow_link[slot[IDX_W-1:0]];
        if (next_slot >= NULL_SLOT) begin
          shadow_empty[qid] = 1'b1;
          shadow_head[qid]  = '0;
        end else begin
          shadow_head[qid] = next_slot;
        end
        shadow_link[slot[IDX_W-1:0]] = shadow_free;
        shadow_free                  = slot;
        res.data                     = shadow_data[slot[IDX_W-1:0]];
      end
    end
    return res;
  endfunction

  task automatic add_row(input logic op, input logic [QID_W-1:0] qid,
                         input logic signed [DATA_W-1:0] data, input bit known,
                         input logic [1:0] status, input logic signed [DATA_W-1:0] dout);
    queue_request_t row;
    row.op     = op;
    row.qid    = qid;
    row.data   = data;
    row.known  = known;
    row.status = status;
    row.dout   = dout;
    directed_rows.push_back(row);
  endtask

  // Offers one request beat, possibly after a few idle cycles, and waits for the
  // block to take it. The expectation is queued at the edge of acceptance. Between calls,
  // valid is lowered only by the idle loop of the next call, so it is never written
  // twice in one time step.
  task automatic send_request(input queue_request_t row);
    queue_result_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= row.op;
    in_queue_id <= row.qid;
    in_data_in  <= row.data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_queue_op(row.op, row.qid, row.data);
    if (row.known) begin
      predicted.status = row.status;
      predicted.data   = row.dout;
    end
    awaited_results.push_back(predicted);
  endtask

  // Result side: every beat taken off the output is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat status=%0d data=%h",
                                  out_status, out_data_out));
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
        end
        if (out_data_out !== want.data) begin
          report_mismatch($sformatf("data_out %h, expected %h", out_data_out, want.data));
        end
      end
    end
  end

  // Receiver: random stalls at the current rate. Once, on request, it holds off
  // for a long stretch so the result path backs up and the block must stall its
  // input while the sender keeps offering beats.
  initial begin
    int held;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  // Main sequence: reset, the directed table, then three phases of random traffic.
  initial begin
    queue_request_t row;
    int             i;
    int             phase;
    int             n;
    int             enq_pct;

    mismatch_count    = 0;
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_off_request  = 1'b0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_op       <= OP_ENQ;
    in_queue_id <= '0;
    in_data_in  <= '0;

    // Shadow store after reset: all queues empty, every slot chained on the free list.
    for (i = 0; i < NUM_QUEUES; i++) begin
      shadow_head[i]  = '0;
      shadow_tail[i]  = '0;
      shadow_empty[i] = 1'b1;
    end
    for (i = 0; i < CAPACITY; i++) begin
      shadow_link[i] = SLOT_W'(i + 1);
      shadow_data[i] = '0;
    end
    shadow_free = '0;

    // Directed table. Dequeues from every queue right after reset find it empty.
    for (i = 0; i < NUM_QUEUES; i++) begin
      add_row(OP_DEQ, QID_W'(i), 32'sh0BAD_F00D, 1'b1, ST_EMPTY, '0);
    end
    // Extreme data values go in and are accepted.
    add_row(OP_ENQ, 2'd0, DATA_MIN, 1'b1, ST_OK, '0);
    add_row(OP_ENQ, 2'd3, DATA_MAX, 1'b1, ST_OK, '0);
    add_row(OP_ENQ, 2'd1, '0, 1'b1, ST_OK, '0);
    add_row(OP_ENQ, 2'd2, -32'sd1, 1'b1, ST_OK, '0);
    // Queue 1 drains to empty, then is refilled while holding its stale tail.
    add_row(OP_DEQ, 2'd1, -32'sd1, 1'b1, ST_OK, '0);
    add_row(OP_DEQ, 2'd1, '0, 1'b1, ST_EMPTY, '0);
    add_row(OP_ENQ, 2'd1, 32'sh1234_5678, 1'b0, ST_OK, '0);
    // Fill the remaining slots across all queues; one more enqueue finds no room.
    for (i = 0; i < CAPACITY - 4; i++) begin
      add_row(OP_ENQ, QID_W'(i), 32'sh5A5A_0000 + i, 1'b0, ST_OK, '0);
    end
    add_row(OP_ENQ, 2'd2, 32'sh7777_7777, 1'b1, ST_FULL, '0);
    // Heads come back in arrival order, and a freed slot is reused at once.
    add_row(OP_DEQ, 2'd0, '0, 1'b1, ST_OK, DATA_MIN);
    add_row(OP_DEQ, 2'd3, '0, 1'b1, ST_OK, DATA_MAX);
    add_row(OP_ENQ, 2'd0, 32'sh0F0F_0F0F, 1'b0, ST_OK, '0);
    add_row(OP_DEQ, 2'd2, '0, 1'b1, ST_OK, -32'sd1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_request(directed_rows[i]);

    // Random traffic. Every hundred beats the enqueue share is redrawn at random as heavy,
    // light or even, so the store keeps filling up and draining to empty.
    enq_pct = 50;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct   = 10;
          receiver_idle_pct = 75;
        end
        1: begin
          sender_idle_pct   = 75;
          receiver_idle_pct = 10;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
          hold_off_request  = 1'b1;
        end
      endcase
      for (n = 0; n < RANDOM_BEATS_PER_PHASE; n++) begin
        if (n % 100 == 0) begin
          case ($urandom_range(2))
            0:       enq_pct = 85;
            1:       enq_pct = 15;
            default: enq_pct = 50;
          endcase
        end
        row.op    = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
        row.qid   = QID_W'($urandom_range(NUM_QUEUES - 1));
        row.known = 1'b0;
        case ($urandom_range(7))
          0:       row.data = DATA_MIN;
          1:       row.data = DATA_MAX;
          2:       row.data = '0;
          3:       row.data = -32'sd1;
          default: row.data = $urandom;
        endcase
        send_request(row);
      end
    end
    in_valid <= 1'b0;

    // Let every outstanding result come back, then a few quiet cycles for stray beats.
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("** k_queues_shared_buffer_unit: PASSED **");
    end else begin
      $display("** k_queues_shared_buffer_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(2_000_000);
    $display("** k_queues_shared_buffer_unit: FAILED **");
    $finish;
  end

endmodule
